### hw/rtl/sequence_gap_loss_monitor_macros.svh
// Assertion macros shared by the sequence gap loss monitor RTL.
`ifndef SEQUENCE_GAP_LOSS_MONITOR_MACROS_SVH
`define SEQUENCE_GAP_LOSS_MONITOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property at each rising edge, ignored while reset is high.
`define SGLM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at each rising edge, reset included.
`define SGLM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGLM_ASSERT(label, clk, rst, prop, msg)
`define SGLM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### hw/rtl/sglm_pkg.sv
// Shared constants for the sequence gap loss monitor.
package sglm_pkg;

  localparam int NODE_COUNT = 16;
  localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SEQ_W      = 8;
  localparam int ID_W       = 8;
  localparam int TALLY_W    = 32;
  localparam int MINEXP_W   = 16;
  localparam int RATE_W     = 10;
  localparam int PERMILLE   = 1000;
  localparam int NUM_W      = TALLY_W + RATE_W;
  localparam int STEP_W     = $clog2(NUM_W + 1);
  localparam int QUO_W      = RATE_W + 1;

  localparam logic [RATE_W-1:0] RATE_CAP      = RATE_W'(PERMILLE);
  localparam logic [SEQ_W-1:0]  REORDER_LIMIT = SEQ_W'(128);

endpackage

### hw/rtl/sglm_div.sv
// Shift-subtract divider for the rounded, capped loss rate.
module sglm_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sglm_pkg::TALLY_W-1:0]       lost,
  input  logic [sglm_pkg::TALLY_W-1:0]       expected,
  output logic                               done,
  output logic [sglm_pkg::RATE_W-1:0]        rate
);

  logic                               busy;
  logic [sglm_pkg::STEP_W-1:0]        steps;
  logic [sglm_pkg::NUM_W-1:0]         num;
  logic [sglm_pkg::TALLY_W-1:0]       den;
  logic [sglm_pkg::TALLY_W-1:0]       rem;
  logic [sglm_pkg::QUO_W-1:0]         quo;
  logic                               ovf;
  logic [sglm_pkg::TALLY_W:0]         rem_sh;
  logic                               fits;

  assign rem_sh = {rem, num[sglm_pkg::NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= sglm_pkg::STEP_W'(sglm_pkg::NUM_W);
        // numerator with half the divisor added for rounding
        num   <= {{sglm_pkg::RATE_W{1'b0}}, lost} * sglm_pkg::NUM_W'(sglm_pkg::PERMILLE)
                 + sglm_pkg::NUM_W'(expected >> 1);
        den   <= expected;
        rem   <= '0;
        quo   <= '0;
        ovf   <= 1'b0;
      end else if (busy) begin
        num   <= num << 1;
        rem   <= fits ? sglm_pkg::TALLY_W'(rem_sh - {1'b0, den})
                      : rem_sh[sglm_pkg::TALLY_W-1:0];
        quo   <= {quo[sglm_pkg::QUO_W-2:0], fits};
        // any bit pushed out of the narrow quotient means the cap applies
        ovf   <= ovf | quo[sglm_pkg::QUO_W-1];
        steps <= steps - 1'b1;
        if (steps == sglm_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rate = (ovf || (quo > {1'b0, sglm_pkg::RATE_CAP})) ? sglm_pkg::RATE_CAP
                                                             : quo[sglm_pkg::RATE_W-1:0];

endmodule

### hw/rtl/sequence_gap_loss_monitor.sv
// Per-node sequence gap loss monitor: top level with node table and sequencer.
// Order: a rejected frame passes S_UPDATE and then S_FINISH; a frame whose rate reads zero passes
// S_UPDATE, S_START and S_FINISH; otherwise S_DIVIDE runs the 42-step shift-subtract divider before S_FINISH.
// Flow: one frame at a time, a new one taken only back in S_IDLE;
// a result held by out_ready stalls the input.
// Reset (synchronous, rst high) clears the node table seen bits and loads own_node_id = 1,
// min_expected_count = 10; entries read as zero until a node's first frame.
`include "sequence_gap_loss_monitor_macros.svh"

module sequence_gap_loss_monitor (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // frame header channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sglm_pkg::ID_W-1:0]           source_node,
  input  logic [sglm_pkg::SEQ_W-1:0]          seq_number,
  // statistics channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                accepted,
  output logic [sglm_pkg::ID_W-1:0]           node_index,
  output logic [sglm_pkg::TALLY_W-1:0]        frames_seen,
  output logic [sglm_pkg::TALLY_W-1:0]        frames_lost,
  output logic [sglm_pkg::TALLY_W-1:0]        frames_expected,
  output logic [sglm_pkg::RATE_W-1:0]         loss_permille
);

  localparam logic REG_OWN_NODE = 1'b0;
  localparam logic REG_MIN_EXP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state;

  logic [sglm_pkg::ID_W-1:0]      own_node_id;
  logic [sglm_pkg::MINEXP_W-1:0]  min_expected_count;

  logic [sglm_pkg::NODE_COUNT-1:0] seen_flag;
  logic [sglm_pkg::SEQ_W-1:0]      prior_seq   [sglm_pkg::NODE_COUNT];
  logic [sglm_pkg::TALLY_W-1:0]    frame_tally [sglm_pkg::NODE_COUNT];
  logic [sglm_pkg::TALLY_W-1:0]    lost_tally  [sglm_pkg::NODE_COUNT];

  logic [sglm_pkg::ID_W-1:0]      node_reg;
  logic [sglm_pkg::SEQ_W-1:0]     seq_reg;

  logic                           res_accepted;
  logic [sglm_pkg::TALLY_W-1:0]   res_frames;
  logic [sglm_pkg::TALLY_W-1:0]   res_lost;
  logic [sglm_pkg::TALLY_W-1:0]   res_expected;
  logic [sglm_pkg::RATE_W-1:0]    res_rate;

  logic [sglm_pkg::NODE_W-1:0]    idx;
  logic                           rejected;
  logic                           hit;
  logic [sglm_pkg::SEQ_W-1:0]     old_prior;
  logic [sglm_pkg::TALLY_W-1:0]   old_frames;
  logic [sglm_pkg::TALLY_W-1:0]   old_lost;
  logic [sglm_pkg::SEQ_W-1:0]     gap;
  logic [sglm_pkg::TALLY_W-1:0]   frames_next;
  logic [sglm_pkg::TALLY_W-1:0]   lost_next;
  logic [sglm_pkg::SEQ_W-1:0]     prior_next;
  logic                           table_we;
  logic                           rate_zero;
  logic                           div_start;
  logic                           div_done;
  logic [sglm_pkg::RATE_W-1:0]    div_rate;
  logic                           cfg_we;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id        <= sglm_pkg::ID_W'(1);
      min_expected_count <= sglm_pkg::MINEXP_W'(10);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_OWN_NODE: own_node_id        <= pwdata[sglm_pkg::ID_W-1:0];
        REG_MIN_EXP:  min_expected_count <= pwdata[sglm_pkg::MINEXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OWN_NODE: prdata = {{(32 - sglm_pkg::ID_W){1'b0}}, own_node_id};
      REG_MIN_EXP:  prdata = {{(32 - sglm_pkg::MINEXP_W){1'b0}}, min_expected_count};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- node table update
  assign idx      = node_reg[sglm_pkg::NODE_W-1:0];
  assign rejected = (node_reg == '0) || (node_reg == own_node_id) ||
                    ({1'b0, node_reg} >= 9'(sglm_pkg::NODE_COUNT));

  // an entry not yet seen reads as zero
  assign hit        = seen_flag[idx];
  assign old_prior  = hit ? prior_seq[idx]   : '0;
  assign old_frames = hit ? frame_tally[idx] : '0;
  assign old_lost   = hit ? lost_tally[idx]  : '0;

  assign gap         = seq_reg - old_prior;
  assign frames_next = old_frames + 1'b1;
  assign lost_next   = (hit && (gap != '0) && (gap < sglm_pkg::REORDER_LIMIT))
                       ? old_lost + sglm_pkg::TALLY_W'(gap - 1'b1) : old_lost;
  assign prior_next  = (!hit || (gap != '0)) ? seq_reg : old_prior;

  assign table_we  = (state == S_UPDATE) && !rejected;
  assign rate_zero = (res_expected == '0) ||
                     (res_expected < sglm_pkg::TALLY_W'(min_expected_count));
  assign div_start = (state == S_START) && !rate_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flag <= '0;
    end else if (table_we) begin
      seen_flag[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (table_we) begin
      prior_seq[idx]   <= prior_next;
      frame_tally[idx] <= frames_next;
      lost_tally[idx]  <= lost_next;
    end
  end

  // ---------------------------------------------------------------- divider
  sglm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .lost     (res_lost),
    .expected (res_expected),
    .done     (div_done),
    .rate     (div_rate)
  );

  // ---------------------------------------------------------------- sequencer
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop a taken beat unless the next one replaces it this cycle
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            node_reg <= source_node;
            seq_reg  <= seq_number;
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          res_rate <= '0;
          if (rejected) begin
            res_accepted <= 1'b0;
            res_frames   <= '0;
            res_lost     <= '0;
            res_expected <= '0;
            state        <= S_FINISH;
          end else begin
            res_accepted <= 1'b1;
            res_frames   <= frames_next;
            res_lost     <= lost_next;
            res_expected <= frames_next + lost_next;
            state        <= S_START;
          end
        end
        S_START: begin
          state <= rate_zero ? S_FINISH : S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            res_rate <= div_rate;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            accepted        <= res_accepted;
            node_index      <= res_accepted ? node_reg : '0;
            frames_seen     <= res_frames;
            frames_lost     <= res_lost;
            frames_expected <= res_expected;
            loss_permille   <= res_rate;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  `SGLM_ASSERT(a_rate_capped, clk, rst, out_valid |-> loss_permille <= sglm_pkg::RATE_CAP, "loss rate above cap")
  `SGLM_ASSERT(a_expected_sum, clk, rst, (out_valid && accepted) |-> frames_expected == frames_seen + frames_lost, "expected count mismatch")
  `SGLM_ASSERT(a_reject_zero, clk, rst, (out_valid && !accepted) |-> (frames_seen == '0 && frames_lost == '0 && loss_permille == '0), "rejected beat carries data")
  `SGLM_ASSERT(a_div_done_in_divide, clk, rst, div_done |-> state == S_DIVIDE, "divider finished outside divide phase")
  `SGLM_ASSERT(a_node_filtered, clk, rst, (out_valid && accepted) |-> (node_index != '0 && node_index != own_node_id), "filtered node reported")

endmodule
